/* hdl/kaft_pkg.sv */
package kaft_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 16;
    localparam int MASK_W  = 64;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_SET    = 2'd2;
    localparam logic [1:0] ACT_MARK   = 2'd3;

    localparam logic [1:0] ST_ABSENT  = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

/* hdl/kaft_ctrl.sv */
module kaft_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output kaft_pkg::ctrl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

/* hdl/kaft_datapath.sv */
module kaft_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kaft_pkg::ctrl_cmd_t           cmd,
    input  logic [1:0]                    action,
    input  logic [kaft_pkg::KEY_W-1:0]    flag_id,
    input  logic [kaft_pkg::MASK_W-1:0]   mask_in,
    input  logic                          invalid_in,
    input  logic                          cfg_wr_en,
    input  logic [kaft_pkg::KEY_W-1:0]    cfg_wr_data,
    output logic [1:0]                    status,
    output logic [kaft_pkg::MASK_W-1:0]   mask_out
);

    logic [1:0]                  action_reg;
    logic [kaft_pkg::KEY_W-1:0]  id_reg;
    logic [kaft_pkg::MASK_W-1:0] mask_in_reg;
    logic                        inv_in_reg;
    logic [kaft_pkg::KEY_W-1:0]  reset_id_reg;

    logic [kaft_pkg::ENTRIES-1:0] used_reg;
    logic [kaft_pkg::KEY_W-1:0]   key_reg  [kaft_pkg::ENTRIES];
    logic                         inv_reg  [kaft_pkg::ENTRIES];
    logic [kaft_pkg::MASK_W-1:0]  mask_reg [kaft_pkg::ENTRIES];

    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [kaft_pkg::MASK_W-1:0] mask_out_reg;
    logic [kaft_pkg::MASK_W-1:0] mask_out_next;

    logic                         hit;
    logic [kaft_pkg::SLOT_W-1:0]  hit_idx;
    logic                         free_found;
    logic [kaft_pkg::SLOT_W-1:0]  free_idx;
    logic                         inv_sel;
    logic [kaft_pkg::MASK_W-1:0]  mask_sel;
    logic                         is_reset_id;

    // Keys are unique in the table, so at most one slot matches.
    always_comb
    begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < kaft_pkg::ENTRIES; i++)
        begin
            if (used_reg[i] && (key_reg[i] == id_reg))
            begin
                hit     = 1'b1;
                hit_idx = kaft_pkg::SLOT_W'(i);
            end
            if (!used_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = kaft_pkg::SLOT_W'(i);
            end
        end
    end

    assign inv_sel     = inv_reg[hit_idx];
    assign mask_sel    = mask_reg[hit_idx];
    assign is_reset_id = (id_reg == reset_id_reg);

    always_comb
    begin
        status_next   = kaft_pkg::ST_ABSENT;
        mask_out_next = '0;
        case (action_reg)
            kaft_pkg::ACT_CREATE:
            begin
                if (hit)
                begin
                    status_next   = inv_sel ? kaft_pkg::ST_INVALID : kaft_pkg::ST_VALID;
                    mask_out_next = mask_sel;
                end
                else if (free_found)
                begin
                    status_next = kaft_pkg::ST_INVALID;
                end
                else
                begin
                    status_next = kaft_pkg::ST_FULL;
                end
            end
            kaft_pkg::ACT_LOOKUP:
            begin
                if (hit)
                begin
                    status_next   = inv_sel ? kaft_pkg::ST_INVALID : kaft_pkg::ST_VALID;
                    mask_out_next = mask_sel;
                end
            end
            kaft_pkg::ACT_SET:
            begin
                if (hit)
                begin
                    status_next   = kaft_pkg::ST_VALID;
                    mask_out_next = mask_in_reg;
                end
            end
            kaft_pkg::ACT_MARK:
            begin
                if (hit)
                begin
                    if (is_reset_id || inv_in_reg)
                    begin
                        status_next = kaft_pkg::ST_INVALID;
                    end
                    else
                    begin
                        status_next = kaft_pkg::ST_VALID;
                    end
                    mask_out_next = mask_sel;
                end
            end
            default:
            begin
                status_next   = kaft_pkg::ST_ABSENT;
                mask_out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_id_reg <= '0;
            used_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reset_id_reg <= cfg_wr_data;
            end
            if (cmd.exec && (action_reg == kaft_pkg::ACT_CREATE) && !hit && free_found)
            begin
                used_reg[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= action;
            id_reg      <= flag_id;
            mask_in_reg <= mask_in;
            inv_in_reg  <= invalid_in;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            mask_out_reg <= mask_out_next;
            case (action_reg)
                kaft_pkg::ACT_CREATE:
                begin
                    if (!hit && free_found)
                    begin
                        key_reg[free_idx]  <= id_reg;
                        inv_reg[free_idx]  <= 1'b1;
                        mask_reg[free_idx] <= '0;
                    end
                end
                kaft_pkg::ACT_SET:
                begin
                    if (hit)
                    begin
                        mask_reg[hit_idx] <= mask_in_reg;
                        inv_reg[hit_idx]  <= 1'b0;
                    end
                end
                kaft_pkg::ACT_MARK:
                begin
                    if (is_reset_id)
                    begin
                        for (int i = 0; i < kaft_pkg::ENTRIES; i++)
                        begin
                            inv_reg[i] <= 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        inv_reg[hit_idx] <= inv_in_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status   = status_reg;
    assign mask_out = mask_out_reg;

endmodule

/* hdl/keyed_affinity_flag_table.sv */
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    action, flag_id, mask_in, invalid_in
// result    out        done, one cycle         status, mask_out
// config    in         cfg_wr_en               cfg_wr_data (reset ID)
//
// Each transaction first captures the request; then the parallel key compare over all table
// slots updates the table and registers the result.
// The result appears with done in the same cycle as busy falls, while a new request may
// already be taken. Reset clears the slot occupancy and the reset ID at once.
// The receiver cannot stall; done is a single-cycle strobe.
module keyed_affinity_flag_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [kaft_pkg::KEY_W-1:0]  flag_id,
    input  logic [kaft_pkg::MASK_W-1:0] mask_in,
    input  logic                        invalid_in,
    input  logic                        cfg_wr_en,
    input  logic [kaft_pkg::KEY_W-1:0]  cfg_wr_data,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [kaft_pkg::MASK_W-1:0] mask_out
);

    kaft_pkg::ctrl_cmd_t cmd;

    kaft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    kaft_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .flag_id     (flag_id),
        .mask_in     (mask_in),
        .invalid_in  (invalid_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .mask_out    (mask_out)
    );

endmodule

/* hdl/kaft_checker.sv */
module kaft_protocol_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  action,
    input logic                        done,
    input logic [1:0]                  status,
    input logic [kaft_pkg::MASK_W-1:0] mask_out
);

    // Every accepted transaction occupies exactly one busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
    else $error("result strobe missing after busy cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

    // A full status can only answer a create, and then carries no mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == kaft_pkg::ST_FULL)) |->
            (($past(action, 2) == kaft_pkg::ACT_CREATE) && (mask_out == '0)))
    else $error("full status on a request other than create");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == kaft_pkg::ST_ABSENT)) |-> (mask_out == '0))
    else $error("absent entry reported a nonzero mask");

endmodule

bind keyed_affinity_flag_table kaft_protocol_checker u_kaft_checker (.*);

/* sim/kaft_checker.sv */
`timescale 1ns / 100ps
module kaft_checker
    import kaft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        action,
    input  logic [KEY_W-1:0]  flag_id,
    input  logic [MASK_W-1:0] mask_in,
    input  logic              invalid_in,
    input  logic              cfg_wr_en,
    input  logic [KEY_W-1:0]  cfg_wr_data,
    input  logic              done,
    input  logic [1:0]        status,
    input  logic [MASK_W-1:0] mask_out,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [MASK_W-1:0] mask;
    } entry_view_t;

    logic [KEY_W-1:0]  reset_key;
    logic              slot_used  [ENTRIES];
    logic [KEY_W-1:0]  slot_key   [ENTRIES];
    logic              slot_stale [ENTRIES];
    logic [MASK_W-1:0] slot_mask  [ENTRIES];
    entry_view_t       expected_views [$];

    function automatic entry_view_t apply_request(
        input logic [1:0]        act,
        input logic [KEY_W-1:0]  id,
        input logic [MASK_W-1:0] new_mask,
        input logic              new_stale
    );
        int          hit;
        int          free;
        int          i;
        entry_view_t view;
        hit  = -1;
        free = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_key[i] == id)
                hit = i;
            if (free < 0 && !slot_used[i])
                free = i;
        end
        case (act)
            ACT_CREATE:
            begin
                if (hit < 0)
                begin
                    if (free < 0)
                    begin
                        view.status = ST_FULL;
                        view.mask   = '0;
                        return view;
                    end
                    hit              = free;
                    slot_used[hit]   = 1'b1;
                    slot_key[hit]    = id;
                    slot_stale[hit]  = 1'b1;
                    slot_mask[hit]   = '0;
                end
            end
            ACT_SET:
            begin
                if (hit >= 0)
                begin
                    slot_mask[hit]  = new_mask;
                    slot_stale[hit] = 1'b0;
                end
            end
            ACT_MARK:
            begin
                if (id == reset_key)
                begin
                    for (i = 0; i < ENTRIES; i++)
                        if (slot_used[i])
                            slot_stale[i] = 1'b1;
                end
                else if (hit >= 0)
                begin
                    slot_stale[hit] = new_stale;
                end
            end
            default:
            begin
            end
        endcase
        if (hit < 0)
        begin
            view.status = ST_ABSENT;
            view.mask   = '0;
        end
        else
        begin
            view.status = slot_stale[hit] ? ST_INVALID : ST_VALID;
            view.mask   = slot_mask[hit];
        end
        return view;
    endfunction

    // Results are compared before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        entry_view_t want;
        if (!rst_n)
        begin
            reset_key = '0;
            for (int i = 0; i < ENTRIES; i++)
                slot_used[i] = 1'b0;
            expected_views.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_views.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no transaction waiting: status %0d mask %h",
                             $time, status, mask_out);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (mask_out !== want.mask)
                    begin
                        fail_count++;
                        $display("%0t: mask_out expected %h actual %h",
                                 $time, want.mask, mask_out);
                    end
                end
            end
            if (cfg_wr_en)
                reset_key = cfg_wr_data;
            if (start && !busy)
                expected_views.push_back(apply_request(action, flag_id, mask_in, invalid_in));
            pending = expected_views.size();
        end
    end

endmodule

/* sim/tb_keyed_affinity_flag_table.sv */
`timescale 1ns / 100ps
module tb_keyed_affinity_flag_table;
    import kaft_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int POOL_SIZE       = 20;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    logic [KEY_W-1:0]  flag_id;
    logic [MASK_W-1:0] mask_in;
    logic              invalid_in;
    logic              cfg_wr_en;
    logic [KEY_W-1:0]  cfg_wr_data;
    logic              done;
    logic [1:0]        status;
    logic [MASK_W-1:0] mask_out;

    int                fail_count;
    int                pending;
    int                stall_cycles = 0;
    int                idle_pct = 0;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [KEY_W-1:0]  current_reset_key;

    keyed_affinity_flag_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .flag_id     (flag_id),
        .mask_in     (mask_in),
        .invalid_in  (invalid_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .status      (status),
        .mask_out    (mask_out)
    );

    kaft_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .flag_id     (flag_id),
        .mask_in     (mask_in),
        .invalid_in  (invalid_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .status      (status),
        .mask_out    (mask_out),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(
        input logic [1:0]        act,
        input logic [KEY_W-1:0]  id,
        input logic [MASK_W-1:0] new_mask,
        input logic              new_stale
    );
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        action     = act;
        flag_id    = id;
        mask_in    = new_mask;
        invalid_in = new_stale;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_table_quiet();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reset_key(input logic [KEY_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en         = 1'b0;
        current_reset_key = value;
    endtask

    task automatic send_random_request();
        logic [1:0]        act;
        logic [KEY_W-1:0]  id;
        logic [MASK_W-1:0] new_mask;
        int                pick;
        act  = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 80)
            id = key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 88)
            id = current_reset_key;
        else
            id = KEY_W'($urandom_range(65535));
        pick = $urandom_range(9);
        if (pick == 0)
            new_mask = '0;
        else if (pick == 1)
            new_mask = '1;
        else
            new_mask = {$urandom(), $urandom()};
        send_request(act, id, new_mask, 1'($urandom_range(1)));
    endtask

    initial
    begin
        int phase;
        start       = 1'b0;
        action      = ACT_LOOKUP;
        flag_id     = '0;
        mask_in     = '0;
        invalid_in  = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        rst_n       = 1'b0;
        current_reset_key = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(65535));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reset_key(16'h0000);
        send_request(ACT_LOOKUP, 16'h0000, '0, 1'b0);
        send_request(ACT_SET,    16'hFFFF, '1, 1'b0);
        send_request(ACT_MARK,   16'hFFFF, '1, 1'b1);
        send_request(ACT_CREATE, 16'hFFFF, '1, 1'b1);
        send_request(ACT_CREATE, 16'hFFFF, '0, 1'b0);
        send_request(ACT_SET,    16'hFFFF, '1, 1'b0);
        send_request(ACT_LOOKUP, 16'hFFFF, '0, 1'b1);
        send_request(ACT_CREATE, 16'h0000, '1, 1'b0);
        send_request(ACT_SET,    16'h0000, '0, 1'b1);
        send_request(ACT_MARK,   16'hFFFF, '0, 1'b1);
        send_request(ACT_MARK,   16'hFFFF, '1, 1'b0);
        send_request(ACT_CREATE, 16'h5A5A, '0, 1'b0);
        send_request(ACT_SET,    16'h5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        send_request(ACT_LOOKUP, 16'h5A5A, '0, 1'b0);
        send_request(ACT_MARK,   16'h0000, '0, 1'b0);
        send_request(ACT_LOOKUP, 16'hFFFF, '0, 1'b0);
        send_request(ACT_LOOKUP, 16'h5A5A, '0, 1'b0);
        send_request(ACT_MARK,   16'h1357, '0, 1'b0);
        send_request(ACT_SET,    16'hFFFF, 64'h8000_0000_0000_0001, 1'b1);
        send_request(ACT_MARK,   16'h5A5A, '0, 1'b0);
        send_request(ACT_LOOKUP, 16'h5A5A, '0, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            wait_table_quiet();
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    write_reset_key(16'hFFFF);
                end
                1:
                begin
                    idle_pct = 49;
                    write_reset_key(KEY_W'($urandom_range(65535)));
                end
                2:
                begin
                    idle_pct = 0;
                    write_reset_key(16'h0000);
                end
                default:
                begin
                    idle_pct = 14;
                    write_reset_key(key_pool[$urandom_range(POOL_SIZE - 1)]);
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_request();
        end

        wait_table_quiet();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/kaft_pkg.sv
hdl/kaft_ctrl.sv
hdl/kaft_datapath.sv
hdl/keyed_affinity_flag_table.sv
hdl/kaft_checker.sv
sim/kaft_checker.sv
sim/tb_keyed_affinity_flag_table.sv
